FILE: rtl/nfsa_pkg.sv
package nfsa_pkg;

  localparam int Slots = 64;
  localparam int SlotW = $clog2(Slots);
  localparam int OffW = 32;
  localparam int OwnerW = 16;
  localparam int SizeW = 32;
  localparam int TotalW = 32;

  localparam logic [TotalW-1:0] TotalReset = TotalW'(65536);

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree = 1'b1;

  typedef enum logic [1:0] {
    StatAllocOk   = 2'd0,
    StatAllocFail = 2'd1,
    StatFreed     = 2'd2,
    StatFreeFail  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StPick,
    StFree
  } state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic alloc_commit;
    logic alloc_fail;
    logic free_read;
    logic free_commit;
    logic free_fail;
  } dp_cmd_t;

  typedef struct packed {
    logic kind_free;
    logic fits;
    logic alloc_hit;
    logic free_hit;
  } dp_stat_t;

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [SlotW-1:0] lowest_set(input logic [Slots-1:0] vec);
    logic [SlotW-1:0] idx;
    idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (vec[i]) idx = SlotW'(i);
    end
    return idx;
  endfunction

endpackage

FILE: rtl/nfsa_ram.sv
module nfsa_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/nfsa_ctrl.sv
module nfsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  nfsa_pkg::dp_stat_t stat_i,
  output logic               busy_o,
  output nfsa_pkg::dp_cmd_t  cmd_o
);

  nfsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfsa_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = 1'b1;
    case (state_q)
      nfsa_pkg::StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = nfsa_pkg::StEval;
        end
      end
      nfsa_pkg::StEval: begin
        cmd_o.eval = 1'b1;
        state_d = nfsa_pkg::StPick;
      end
      nfsa_pkg::StPick: begin
        state_d = nfsa_pkg::StIdle;
        if (!stat_i.kind_free) begin
          if (stat_i.fits && stat_i.alloc_hit) cmd_o.alloc_commit = 1'b1;
          else cmd_o.alloc_fail = 1'b1;
        end else if (stat_i.free_hit) begin
          // fetch the slot size before releasing it
          cmd_o.free_read = 1'b1;
          state_d = nfsa_pkg::StFree;
        end else begin
          cmd_o.free_fail = 1'b1;
        end
      end
      nfsa_pkg::StFree: begin
        cmd_o.free_commit = 1'b1;
        state_d = nfsa_pkg::StIdle;
      end
      default: begin
        state_d = nfsa_pkg::StIdle;
      end
    endcase
  end

endmodule

FILE: rtl/nfsa_dp.sv
module nfsa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nfsa_pkg::dp_cmd_t             cmd_i,
  output nfsa_pkg::dp_stat_t            stat_o,
  input  logic                          cfg_we_i,
  input  logic [nfsa_pkg::TotalW-1:0]   cfg_total_i,
  input  logic                          kind_i,
  input  logic [nfsa_pkg::OwnerW-1:0]   owner_id_i,
  input  logic [nfsa_pkg::SizeW-1:0]    request_size_i,
  input  logic [nfsa_pkg::OffW-1:0]     free_offset_in_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [nfsa_pkg::SlotW-1:0]    slot_o,
  output logic [nfsa_pkg::OffW-1:0]     block_offset_o,
  output logic [nfsa_pkg::OffW-1:0]     used_now_o
);

  localparam int Slots = nfsa_pkg::Slots;
  localparam int SlotW = nfsa_pkg::SlotW;
  localparam int OffW = nfsa_pkg::OffW;

  // captured request
  logic                        kind_q;
  logic [nfsa_pkg::OwnerW-1:0] owner_q;
  logic [nfsa_pkg::SizeW-1:0]  size_q;
  logic [OffW-1:0]             foff_q;

  logic [nfsa_pkg::TotalW-1:0] total_q;
  logic [Slots-1:0]            free_q;
  logic [nfsa_pkg::OwnerW-1:0] slot_owner_q [Slots];
  logic [OffW-1:0]             slot_off_q [Slots];
  logic [OffW-1:0]             bump_q, used_q;
  logic [SlotW-1:0]            next_q;

  logic [Slots-1:0] match_q, match_d;
  logic [Slots-1:0] rot_q, rot_d;
  logic             fits_q, fits_d;
  logic [SlotW-1:0] free_slot_q;

  logic                done_q;
  nfsa_pkg::status_e   status_q;
  logic [SlotW-1:0]    out_slot_q;
  logic [OffW-1:0]     out_off_q, out_used_q;

  logic [2*Slots-1:0]  free_dbl;
  logic [SlotW-1:0]    alloc_idx, free_idx;
  logic [OffW-1:0]     size_ext, limit, size_rd;

  assign size_ext = OffW'(size_q);
  assign limit = OffW'(total_q);

  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      match_d[i] = !free_q[i] && (slot_owner_q[i] == owner_q) && (slot_off_q[i] == foff_q);
    end
    // rotate so that bit zero is the slot at the next-fit pointer
    free_dbl = {free_q, free_q} >> next_q;
    rot_d = free_dbl[Slots-1:0];
    fits_d = (size_ext <= limit) && (bump_q <= limit - size_ext);
  end

  assign alloc_idx = next_q + nfsa_pkg::lowest_set(rot_q);
  assign free_idx = nfsa_pkg::lowest_set(match_q);

  assign stat_o.kind_free = (kind_q == nfsa_pkg::KindFree);
  assign stat_o.fits = fits_q;
  assign stat_o.alloc_hit = |rot_q;
  assign stat_o.free_hit = |match_q;

  nfsa_ram #(
    .Width(OffW),
    .Depth(Slots)
  ) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.alloc_commit),
    .waddr_i(alloc_idx),
    .wdata_i(size_ext),
    .raddr_i(free_idx),
    .rdata_o(size_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      owner_q <= owner_id_i;
      size_q <= request_size_i;
      foff_q <= free_offset_in_i;
    end
    if (cmd_i.eval) begin
      match_q <= match_d;
      rot_q <= rot_d;
      fits_q <= fits_d;
    end
    if (cmd_i.free_read) free_slot_q <= free_idx;
    if (cmd_i.alloc_commit) begin
      slot_owner_q[alloc_idx] <= owner_q;
      slot_off_q[alloc_idx] <= bump_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= nfsa_pkg::TotalReset;
      free_q <= '1;
      bump_q <= '0;
      used_q <= '0;
      next_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) total_q <= cfg_total_i;
      done_q <= cmd_i.alloc_commit | cmd_i.alloc_fail | cmd_i.free_commit | cmd_i.free_fail;
      if (cmd_i.alloc_commit) begin
        free_q[alloc_idx] <= 1'b0;
        bump_q <= bump_q + size_ext;
        used_q <= used_q + size_ext;
        next_q <= alloc_idx + SlotW'(1);
      end
      if (cmd_i.free_commit) begin
        free_q[free_slot_q] <= 1'b1;
        used_q <= used_q - size_rd;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_commit) begin
      status_q <= nfsa_pkg::StatAllocOk;
      out_slot_q <= alloc_idx;
      out_off_q <= bump_q;
      out_used_q <= used_q + size_ext;
    end else if (cmd_i.alloc_fail) begin
      status_q <= nfsa_pkg::StatAllocFail;
      out_slot_q <= '0;
      out_off_q <= '0;
      out_used_q <= used_q;
    end else if (cmd_i.free_commit) begin
      status_q <= nfsa_pkg::StatFreed;
      out_slot_q <= free_slot_q;
      out_off_q <= foff_q;
      out_used_q <= used_q - size_rd;
    end else if (cmd_i.free_fail) begin
      status_q <= nfsa_pkg::StatFreeFail;
      out_slot_q <= '0;
      out_off_q <= '0;
      out_used_q <= used_q;
    end
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign slot_o = out_slot_q;
  assign block_offset_o = out_off_q;
  assign used_now_o = out_used_q;

endmodule

FILE: rtl/next_fit_slot_allocator.sv
// Next-fit slot allocator: 64 block descriptors, a rotating next-fit pointer,
// a bump offset that only grows and a used-byte count.
// Request channel: a request (kind, owner, size, offset) is taken at a rising
// edge with start high and busy low. Allocate takes the first free slot at or
// after the pointer if bump offset plus size fits in total_bytes; free releases
// the lowest occupied slot whose owner and offset match.
// Result channel: done_o is high for exactly one cycle with status, slot,
// offset and used count; the receiver must take it then, it cannot stall.
// Timing: an allocate passes through the capture, the registered match and
// free-slot rotate stage and the circular priority encode; a free adds the
// registered read of the size RAM. busy is low again in the cycle the result
// shows, so a new request is taken only once the last result shows.
// Configuration: cfg_valid_i writes total_bytes; ready is always high. Write it
// only while no request is in flight.
// Reset: every slot free, pointer, bump offset and used count zero,
// total_bytes 65536.
module next_fit_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [15:0] owner_id_i,
  input  logic [31:0] request_size_i,
  input  logic [31:0] free_offset_in_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_o,
  output logic [31:0] block_offset_o,
  output logic [31:0] used_now_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_total_bytes_i
);

  nfsa_pkg::dp_cmd_t  cmd;
  nfsa_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  nfsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  nfsa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_total_i     (cfg_total_bytes_i),
    .kind_i          (kind_i),
    .owner_id_i      (owner_id_i),
    .request_size_i  (request_size_i),
    .free_offset_in_i(free_offset_in_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .block_offset_o  (block_offset_o),
    .used_now_o      (used_now_o)
  );

endmodule

FILE: rtl/nfsa_chk.sv
module nfsa_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [5:0]  slot_o,
  input logic [31:0] block_offset_o
);

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // results never come back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // a result only ends a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in flight");

  // failures report slot and offset as zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == 2'(nfsa_pkg::StatAllocFail) ||
               status_o == 2'(nfsa_pkg::StatFreeFail))
      |-> slot_o == '0 && block_offset_o == '0)
    else $error("failed request reports a slot or offset");

endmodule

bind next_fit_slot_allocator nfsa_chk u_nfsa_chk (.*);
